// ----- hdl/dpskm_pkg.sv -----
// Shared constants, codes and elaboration-time helpers for the DPSK frame modulator.
// No dependencies; imported by dpskm_carrier_rom and dpsk_frame_modulator.
`default_nettype none

package dpskm_pkg;

  // Field widths
  localparam int DATA_W     = 24;
  localparam int SAMPLE_W   = 16;
  localparam int BITNUM_W   = 5;
  localparam int PREAMBLE_W = 8;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 8;
  localparam int PREAMBLE_SHIFT = 16;

  // Default build parameters
  localparam int DEF_SAMPLES_PER_BIT   = 20;
  localparam int DEF_BITS_PER_FRAME    = 25;
  localparam int DEF_SAMPLES_PER_CYCLE = 10;

  // Configuration reset values
  localparam logic                  PREAMBLE_ENABLE_RST = 1'b1;
  localparam logic [PREAMBLE_W-1:0] PREAMBLE_BYTE_RST   = 8'hff;

  // Carrier arithmetic, Q62 sine scaled to the DAC range
  localparam logic [63:0] MID_LEVEL   = 64'd32767;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] AMP_NUM     = 64'd131068;
  localparam logic [63:0] AMP_DEN_Q42 = 64'd5 << 42;

  // Taylor series denominators (2n)(2n+1) for n = 1..14
  localparam int TAYLOR_TERMS = 14;
  localparam logic [9:0] TAYLOR_DEN [TAYLOR_TERMS] = '{
    10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156, 10'd210,
    10'd272, 10'd342, 10'd420, 10'd506, 10'd600, 10'd702, 10'd812
  };

  // Input item kinds carried in tuser
  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_TICK = 1'b1
  } mode_t;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PREAMBLE_ENABLE = 4'd0,
    REG_PREAMBLE_BYTE   = 4'd1
  } cfg_reg_t;

  // One result item as held in the output stages
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [BITNUM_W-1:0] bit_number;
    logic                phase_is_pi;
    logic                last_of_frame;
  } result_t;

  // (a*b) >> 62 for operands below 2^63; used only to build constant tables
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/dpskm_carrier_rom.sv -----
// Carrier sample tables for both phases, indexed by the tick within a bit slot.
// Depends on dpskm_pkg for the Q62 sine helpers and scaling constants.
`default_nettype none

module dpskm_carrier_rom
  import dpskm_pkg::*;
#(
  parameter int SAMPLES_PER_BIT   = DEF_SAMPLES_PER_BIT,
  parameter int SAMPLES_PER_CYCLE = DEF_SAMPLES_PER_CYCLE,
  localparam int IDX_W = $clog2(SAMPLES_PER_BIT)
) (
  input  wire logic [IDX_W-1:0]    tick_idx,
  input  wire logic                phase_is_pi,
  output logic      [SAMPLE_W-1:0] sample
);

  // Compute one table entry: quadrant fold, Taylor sine, scale and floor
  function automatic logic [SAMPLE_W-1:0] carrier_value(input int j, input logic phase);
    logic [63:0] k;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] num;
    logic [63:0] v;
    logic        neg;
    k = 64'(j) % 64'(SAMPLES_PER_CYCLE);
    q = (64'd4 * k) / 64'(SAMPLES_PER_CYCLE);
    r = 64'd4 * k - q * 64'(SAMPLES_PER_CYCLE);
    if (q[0]) begin
      r = 64'(SAMPLES_PER_CYCLE) - r;
    end
    x    = (HALF_PI_Q62 / 64'(SAMPLES_PER_CYCLE)) * r;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = mul_q62(term, x2) / 64'(TAYLOR_DEN[n-1]);
      if (n % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    neg = (q >= 64'd2) != phase;
    num = (sum >> 20) * AMP_NUM;
    if (neg) begin
      v = (num + AMP_DEN_Q42 - 64'd1) / AMP_DEN_Q42;
      return SAMPLE_W'(MID_LEVEL - v);
    end
    v = num / AMP_DEN_Q42;
    return SAMPLE_W'(MID_LEVEL + v);
  endfunction

  logic [SAMPLE_W-1:0] rom_p0 [SAMPLES_PER_BIT];
  logic [SAMPLE_W-1:0] rom_pi [SAMPLES_PER_BIT];

  // Fill both tables at elaboration
  for (genvar g = 0; g < SAMPLES_PER_BIT; g++) begin : g_rom
    localparam logic [SAMPLE_W-1:0] ValP0 = carrier_value(g, 1'b0);
    localparam logic [SAMPLE_W-1:0] ValPi = carrier_value(g, 1'b1);
    assign rom_p0[g] = ValP0;
    assign rom_pi[g] = ValPi;
  end

  // Pick the entry for the current phase
  assign sample = phase_is_pi ? rom_pi[tick_idx] : rom_p0[tick_idx];

endmodule

`default_nettype wire

// ----- hdl/dpsk_frame_modulator.sv -----
// Top level of the differential BPSK frame modulator: frame state, config and output stages.
// Depends on dpskm_pkg and dpskm_carrier_rom.
//
// Usage: each input request is either a load (tuser = 0, tdata = 24-bit word) or a
// sample tick (tuser = 1). A load latches the word, adding preamble_byte << 16 when
// preamble_enable is set, and restarts the frame; it gives no output. Each tick of an
// active frame gives one output request: tdata holds the DAC sample and the bit slot,
// tuser the phase flag and tlast marks the final sample of the frame. A frame is
// BITS_PER_FRAME slots of SAMPLES_PER_BIT ticks; slot 0 is the phase-0 reference and
// each 1 bit that follows flips the carrier. Ticks while idle are taken and dropped.
// The block takes one request per clock cycle while in_tready is high: the result is
// formed combinationally from the frame counters, the phase bit and a constant sample
// table and captured at the accepting edge in the output register, which offers it in
// the next cycle, or in the skid register while the output stalls. A two-entry output
// stage (output register plus skid register) keeps the input open for one more request
// while a result waits; in_tready drops only when both entries are full.
`default_nettype none

module dpsk_frame_modulator
  import dpskm_pkg::*;
#(
  parameter int SAMPLES_PER_BIT   = DEF_SAMPLES_PER_BIT,
  parameter int BITS_PER_FRAME    = DEF_BITS_PER_FRAME,
  parameter int SAMPLES_PER_CYCLE = DEF_SAMPLES_PER_CYCLE
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [23:0]           in_tdata,   // [23:0] data_word
  input  wire logic                  in_tuser,   // [0] mode
  // Result channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [23:0]           out_tdata,  // [15:0] sample, [20:16] bit_number, [23:21] 0
  output logic                       out_tuser,  // [0] phase_is_pi
  output logic                       out_tlast,  // last_of_frame
  // Configuration channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SC_W  = $clog2(SAMPLES_PER_BIT);
  localparam int BC_W  = $clog2(BITS_PER_FRAME);
  localparam int POS_W = $clog2(BITS_PER_FRAME - 1);
  localparam int POS_N = 2 ** POS_W;

  // Configuration registers
  logic                  preamble_enable_r;
  logic [PREAMBLE_W-1:0] preamble_byte_r;

  // Frame state
  logic [DATA_W-1:0] frame_word_r, frame_word_nxt;
  logic [BC_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [SC_W-1:0]   sample_cnt_r, sample_cnt_nxt;
  logic              phase_r, phase_nxt;
  logic              active_r, active_nxt;

  // Output stages
  result_t out_r, skid_r;
  logic    out_v_r, skid_v_r;

  logic                in_fire;
  logic                is_tick;
  logic                res_v;
  logic                last_sample;
  logic                slot_end;
  logic [DATA_W-1:0]   load_word;
  logic [POS_N-1:0]    slot_bits;
  logic [BC_W-1:0]     next_pos;
  logic [SAMPLE_W-1:0] rom_sample;
  result_t             res;

  assign cfg_ready = 1'b1;
  assign in_tready = !skid_v_r;
  assign in_fire   = in_tvalid && in_tready;
  assign is_tick   = (in_tuser == MODE_TICK);
  assign res_v     = in_fire && is_tick && active_r;

  // Write configuration registers; ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      preamble_enable_r <= PREAMBLE_ENABLE_RST;
      preamble_byte_r   <= PREAMBLE_BYTE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_PREAMBLE_ENABLE: preamble_enable_r <= cfg_data[0];
        REG_PREAMBLE_BYTE:   preamble_byte_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Map frame word bits to slot positions; positions above the word read zero
  for (genvar g = 0; g < POS_N; g++) begin : g_slot
    if (g < DATA_W) begin : g_word
      assign slot_bits[g] = frame_word_r[g];
    end else begin : g_pad
      assign slot_bits[g] = 1'b0;
    end
  end

  // Carrier sample table
  dpskm_carrier_rom #(
    .SAMPLES_PER_BIT   (SAMPLES_PER_BIT),
    .SAMPLES_PER_CYCLE (SAMPLES_PER_CYCLE)
  ) u_rom (
    .tick_idx    (sample_cnt_r),
    .phase_is_pi (phase_r),
    .sample      (rom_sample)
  );

  assign slot_end    = (sample_cnt_r == SC_W'(SAMPLES_PER_BIT - 1));
  assign last_sample = slot_end && (bit_cnt_r == BC_W'(BITS_PER_FRAME - 1));
  assign next_pos    = BC_W'(BITS_PER_FRAME - 2) - bit_cnt_r;
  assign load_word   = in_tdata + (preamble_enable_r ? {preamble_byte_r, 16'd0} : '0);

  // Build the result of a tick from the current state
  always_comb begin
    res.sample        = rom_sample;
    res.bit_number    = bit_cnt_r[BITNUM_W-1:0];
    res.phase_is_pi   = phase_r;
    res.last_of_frame = last_sample;
  end

  // Advance the frame state
  always_comb begin
    frame_word_nxt = frame_word_r;
    bit_cnt_nxt    = bit_cnt_r;
    sample_cnt_nxt = sample_cnt_r;
    phase_nxt      = phase_r;
    active_nxt     = active_r;
    if (in_fire && !is_tick) begin
      frame_word_nxt = load_word;
      bit_cnt_nxt    = '0;
      sample_cnt_nxt = '0;
      phase_nxt      = 1'b0;
      active_nxt     = 1'b1;
    end else if (res_v) begin
      if (!slot_end) begin
        sample_cnt_nxt = sample_cnt_r + SC_W'(1);
      end else begin
        sample_cnt_nxt = '0;
        if (last_sample) begin
          bit_cnt_nxt = '0;
          phase_nxt   = 1'b0;
          active_nxt  = 1'b0;
        end else begin
          bit_cnt_nxt = bit_cnt_r + BC_W'(1);
          phase_nxt   = phase_r ^ slot_bits[next_pos[POS_W-1:0]];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_word_r <= '0;
      bit_cnt_r    <= '0;
      sample_cnt_r <= '0;
      phase_r      <= 1'b0;
      active_r     <= 1'b0;
    end else begin
      frame_word_r <= frame_word_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      sample_cnt_r <= sample_cnt_nxt;
      phase_r      <= phase_nxt;
      active_r     <= active_nxt;
    end
  end

  // Output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= res_v;
      end
    end else if (res_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_r <= skid_v_r ? skid_r : res;
    end
    if (out_v_r && !out_tready && res_v) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {3'd0, out_r.bit_number, out_r.sample};
  assign out_tuser  = out_r.phase_is_pi;
  assign out_tlast  = out_r.last_of_frame;

  // Skid entry is filled only behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry valid while output register empty");

  // Counters stay inside the frame
  a_counters_range: assert property (@(posedge clk) disable iff (!rst_n)
    (bit_cnt_r <= BC_W'(BITS_PER_FRAME - 1)) && (sample_cnt_r <= SC_W'(SAMPLES_PER_BIT - 1)))
    else $error("frame counter out of range");

  // An idle block rests at phase zero with cleared counters
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (!phase_r && bit_cnt_r == '0 && sample_cnt_r == '0))
    else $error("idle state not cleared");

  // The final sample of a frame ends it
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (res_v && last_sample) |=> !active_r)
    else $error("frame still active after its last sample");

  // A tick accepted into a free output shows up next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_v && !out_v_r) |=> out_v_r)
    else $error("tick result lost");

endmodule

`default_nettype wire
